FILE: sv/a85_pkg.sv
// shared types and constants for the ascii85 stream encoder
package a85_pkg;

    localparam int A85_DIGITS = 5;
    localparam int A85_RECIP_SHIFT = 38;
    localparam int A85_Q_W = 64 - A85_RECIP_SHIFT;
    localparam int A85_Q_AW = 1;
    localparam int A85_Q_DEPTH = 1 << A85_Q_AW;

    localparam logic [6:0] A85_RADIX = 7'd85;
    localparam logic [6:0] A85_OFFSET = 7'd33;
    localparam logic [6:0] A85_ZERO_CHAR = 7'd122;
    localparam logic [31:0] A85_RECIP = 32'hC0C0C0C1;
    localparam logic [2:0] A85_STEPS = 3'd4;
    localparam logic [1:0] A85_FULL_HELD = 2'd3;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       stream_end;
    } t_in_item;

    typedef struct packed {
        logic [6:0] out_char;
        logic       run_last;
        logic       stream_done;
    } t_out_item;

    typedef struct packed {
        logic [31:0] group_value;
        logic [2:0]  last_idx;
        logic        is_z;
        logic        stream_end;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

FILE: sv/a85_front.sv
// front end: packs bytes into groups and queues finished groups
module a85_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  a85_pkg::t_in_item  i_in_item,
    output logic               o_in_ready,
    input  a85_pkg::t_q_status i_q_status,
    output logic               o_push,
    output a85_pkg::t_job      o_job
);

    logic [31:0] r_group;
    logic [31:0] n_group;
    logic [1:0]  r_held;
    logic [1:0]  n_held;
    logic [31:0] w_shifted;
    logic [31:0] w_group;
    logic        w_fire;
    logic        w_close;
    logic        w_full_group;

    always_comb begin
        case (r_held)
            2'd0: w_shifted = {i_in_item.data_byte, 24'd0};
            2'd1: w_shifted = {8'd0, i_in_item.data_byte, 16'd0};
            2'd2: w_shifted = {16'd0, i_in_item.data_byte, 8'd0};
            default: w_shifted = {24'd0, i_in_item.data_byte};
        endcase
        w_group      = r_group | w_shifted;
        o_in_ready   = !i_q_status.full;
        w_fire       = i_in_valid && o_in_ready;
        w_full_group = (r_held == a85_pkg::A85_FULL_HELD);
        w_close      = w_full_group || i_in_item.stream_end;
        o_push       = w_fire && w_close;

        o_job.group_value = w_group;
        o_job.is_z        = w_full_group && (w_group == 32'd0);
        o_job.last_idx    = o_job.is_z ? 3'd0 : (3'(r_held) + 3'd1);
        o_job.stream_end  = i_in_item.stream_end;

        n_group = r_group;
        n_held  = r_held;
        if (w_fire) begin
            if (w_close) begin
                n_group = 32'd0;
                n_held  = 2'd0;
            end else begin
                n_group = w_group;
                n_held  = r_held + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_group <= 32'd0;
            r_held  <= 2'd0;
        end else begin
            r_group <= n_group;
            r_held  <= n_held;
        end
    end

endmodule

FILE: sv/a85_fifo.sv
// short group queue between front and back
module a85_fifo (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  a85_pkg::t_job      i_job,
    input  logic               i_pop,
    output a85_pkg::t_job      o_job,
    output a85_pkg::t_q_status o_status
);

    a85_pkg::t_job               r_mem [a85_pkg::A85_Q_DEPTH];
    logic [a85_pkg::A85_Q_AW-1:0] r_wp;
    logic [a85_pkg::A85_Q_AW-1:0] n_wp;
    logic [a85_pkg::A85_Q_AW-1:0] r_rp;
    logic [a85_pkg::A85_Q_AW-1:0] n_rp;
    logic [a85_pkg::A85_Q_AW:0]   r_cnt;
    logic [a85_pkg::A85_Q_AW:0]   n_cnt;

    always_comb begin
        o_job           = r_mem[r_rp];
        o_status.full   = (r_cnt == (a85_pkg::A85_Q_AW + 1)'(a85_pkg::A85_Q_DEPTH));
        o_status.empty  = (r_cnt == '0);
        n_wp  = i_push ? r_wp + 1'b1 : r_wp;
        n_rp  = i_pop ? r_rp + 1'b1 : r_rp;
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (i_pop && !i_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

endmodule

FILE: sv/a85_back.sv
// back end: base-85 digit conversion and character output register
module a85_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  a85_pkg::t_q_status  i_q_status,
    input  a85_pkg::t_job       i_job,
    output logic                o_pop,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output a85_pkg::t_out_item  o_out_item
);

    logic        r_cbusy;
    logic        n_cbusy;
    logic [2:0]  r_ccnt;
    logic [2:0]  n_ccnt;
    logic [31:0] r_v;
    logic [31:0] n_v;
    logic [6:0]  r_cd [1:a85_pkg::A85_DIGITS-1];
    logic [6:0]  n_cd [1:a85_pkg::A85_DIGITS-1];
    logic [2:0]  r_clast;
    logic [2:0]  n_clast;
    logic        r_cz;
    logic        n_cz;
    logic        r_cend;
    logic        n_cend;

    logic        r_active;
    logic        n_active;
    logic [6:0]  r_chars [a85_pkg::A85_DIGITS];
    logic [6:0]  n_chars [a85_pkg::A85_DIGITS];
    logic [2:0]  r_left;
    logic [2:0]  n_left;
    logic        r_end;
    logic        n_end;

    logic [63:0]                  w_prod;
    logic [a85_pkg::A85_Q_W-1:0]  w_q;
    logic [6:0]                   w_qm;
    logic [6:0]                   w_rem;
    logic                         w_conv_done;
    logic                         w_em_free;
    logic                         w_handoff;

    always_comb begin
        w_prod = 64'(r_v) * 64'(a85_pkg::A85_RECIP);
        w_q    = w_prod[63:a85_pkg::A85_RECIP_SHIFT];
        // remainder is below 128, so only the low seven bits are needed
        w_qm   = w_q[6:0] * a85_pkg::A85_RADIX;
        w_rem  = r_v[6:0] - w_qm;

        w_conv_done = r_cbusy && (r_cz || (r_ccnt == a85_pkg::A85_STEPS));
        w_em_free   = !r_active || (i_out_ready && (r_left == 3'd0));
        w_handoff   = w_conv_done && w_em_free;
        o_pop       = !i_q_status.empty && (!r_cbusy || w_handoff);

        n_cbusy = r_cbusy;
        n_ccnt  = r_ccnt;
        n_v     = r_v;
        n_cd    = r_cd;
        n_clast = r_clast;
        n_cz    = r_cz;
        n_cend  = r_cend;

        if (r_cbusy && !w_conv_done) begin
            n_v     = 32'(w_q);
            n_cd[1] = w_rem + a85_pkg::A85_OFFSET;
            n_cd[2] = r_cd[1];
            n_cd[3] = r_cd[2];
            n_cd[4] = r_cd[3];
            n_ccnt  = r_ccnt + 3'd1;
        end
        if (w_handoff) begin
            n_cbusy = 1'b0;
        end
        if (o_pop) begin
            n_cbusy = 1'b1;
            n_ccnt  = 3'd0;
            n_v     = i_job.group_value;
            n_clast = i_job.last_idx;
            n_cz    = i_job.is_z;
            n_cend  = i_job.stream_end;
        end

        n_active = r_active;
        n_chars  = r_chars;
        n_left   = r_left;
        n_end    = r_end;

        if (r_active && i_out_ready) begin
            n_chars[0] = r_chars[1];
            n_chars[1] = r_chars[2];
            n_chars[2] = r_chars[3];
            n_chars[3] = r_chars[4];
            n_left     = r_left - 3'd1;
            if (r_left == 3'd0) begin
                n_active = 1'b0;
            end
        end
        if (w_handoff) begin
            n_active   = 1'b1;
            n_chars[0] = r_cz ? a85_pkg::A85_ZERO_CHAR : (r_v[6:0] + a85_pkg::A85_OFFSET);
            n_chars[1] = r_cd[1];
            n_chars[2] = r_cd[2];
            n_chars[3] = r_cd[3];
            n_chars[4] = r_cd[4];
            n_left     = r_cz ? 3'd0 : r_clast;
            n_end      = r_cend;
        end

        o_out_valid            = r_active;
        o_out_item.out_char    = r_chars[0];
        o_out_item.run_last    = (r_left == 3'd0);
        o_out_item.stream_done = (r_left == 3'd0) && r_end;
    end

    always_ff @(posedge i_clk) begin
        r_ccnt  <= n_ccnt;
        r_v     <= n_v;
        r_cd    <= n_cd;
        r_clast <= n_clast;
        r_cz    <= n_cz;
        r_cend  <= n_cend;
        r_chars <= n_chars;
        r_left  <= n_left;
        r_end   <= n_end;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cbusy  <= 1'b0;
            r_active <= 1'b0;
        end else begin
            r_cbusy  <= n_cbusy;
            r_active <= n_active;
        end
    end

endmodule

FILE: sv/ascii85_stream_encoder_top.sv
// ascii85 stream encoder, one byte in and one character out per transaction
// accepts a byte every cycle while the group queue has room
// a closed group passes through the queue, the digit converter and the output register
// digit conversion does four divides by 85 per group, one a cycle, and none for a z group
// throughput is set by the converter and the output; a group converts while the last is output
// synchronous active-low reset empties the group, queue, converter and output
module ascii85_stream_encoder_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  a85_pkg::t_in_item  i_in_item,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output a85_pkg::t_out_item o_out_item
);

    logic               w_push;
    logic               w_pop;
    a85_pkg::t_job      w_job_in;
    a85_pkg::t_job      w_job_out;
    a85_pkg::t_q_status w_q_status;

    a85_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_item  (i_in_item),
        .o_in_ready (o_in_ready),
        .i_q_status (w_q_status),
        .o_push     (w_push),
        .o_job      (w_job_in)
    );

    a85_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_job    (w_job_in),
        .i_pop    (w_pop),
        .o_job    (w_job_out),
        .o_status (w_q_status)
    );

    a85_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_status  (w_q_status),
        .i_job       (w_job_out),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

`ifndef SYNTHESIS
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_q_status.full)
        else $error("group pushed into full queue");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_q_status.empty)
        else $error("group popped from empty queue");

    a_char_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_out_item.out_char >= 7'd33 && o_out_item.out_char <= 7'd117)
            || o_out_item.out_char == 7'd122))
        else $error("output character out of range");

    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.stream_done) |-> o_out_item.run_last)
        else $error("stream end not on last character of run");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");
`endif

endmodule

FILE: sim/tb_ascii85_stream_encoder_top.sv
// self-checking testbench for the ascii85 stream encoder: directed and random byte streams
module tb_ascii85_stream_encoder_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int         CYCLE_LIMIT = 200000;
    localparam int         IDLE_PCT    = 19;
    localparam int         RADIX       = 85;
    localparam int         DIGIT_BASE  = 33;
    localparam logic [6:0] Z_CHAR      = 7'd122;
    localparam int         TAIL_CYCLES = 40;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    a85_pkg::t_in_item  in_item = '0;
    logic               in_ready;
    logic               out_valid;
    logic               out_ready = 1'b0;
    a85_pkg::t_out_item out_item;

    logic [31:0]        grp_word = '0;
    int                 grp_count = 0;
    a85_pkg::t_out_item exp_chars[$];
    a85_pkg::t_out_item want_char;

    bit idle_on = 1'b1;
    int bytes_sent = 0;
    int chars_checked = 0;
    int z_groups = 0;
    int streams_closed = 0;
    int errors = 0;
    int cycles = 0;

    ascii85_stream_encoder_top dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_item   (in_item),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("tb: timeout after %0d cycles, %0d characters pending", cycles,
                     exp_chars.size());
            $display("tb: failure");
            $finish;
        end
    end

    // work out the characters one accepted byte produces
    function automatic void encode_byte(logic [7:0] b, logic last_byte);
        logic [31:0]        v;
        int                 n;
        int                 digit[5];
        a85_pkg::t_out_item ch;

        grp_word = grp_word | ({24'd0, b} << (24 - 8 * grp_count));
        n = grp_count + 1;
        if (n < 4 && !last_byte) begin
            grp_count = n;
            return;
        end
        if (last_byte)
            streams_closed++;
        if (n == 4 && grp_word == 32'd0) begin
            ch.out_char = Z_CHAR;
            ch.run_last = 1'b1;
            ch.stream_done = last_byte;
            exp_chars.push_back(ch);
            z_groups++;
        end else begin
            v = grp_word;
            for (int i = 4; i >= 0; i--) begin
                digit[i] = int'(v % RADIX);
                v = v / RADIX;
            end
            for (int i = 0; i <= n; i++) begin
                ch.out_char = 7'(digit[i] + DIGIT_BASE);
                ch.run_last = (i == n);
                ch.stream_done = (i == n) && last_byte;
                exp_chars.push_back(ch);
            end
        end
        grp_word = '0;
        grp_count = 0;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("tb: mismatch on %s at cycle %0d: got %0d, expected %0d", what, cycles, got,
                 want);
        errors++;
    endtask

    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            chars_checked++;
            if (exp_chars.size() == 0) begin
                report_mismatch("unexpected character", int'(out_item.out_char), 0);
            end else begin
                want_char = exp_chars.pop_front();
                if (out_item.out_char !== want_char.out_char)
                    report_mismatch("out_char", int'(out_item.out_char),
                                    int'(want_char.out_char));
                if (out_item.run_last !== want_char.run_last)
                    report_mismatch("run_last", int'(out_item.run_last),
                                    int'(want_char.run_last));
                if (out_item.stream_done !== want_char.stream_done)
                    report_mismatch("stream_done", int'(out_item.stream_done),
                                    int'(want_char.stream_done));
            end
        end
    end

    always @(negedge clk) begin
        out_ready <= !(idle_on && $urandom_range(99) < IDLE_PCT);
    end

    // one byte per transaction, with random gaps before it while idles are on
    task automatic send_byte(logic [7:0] b, logic last_byte);
        @(negedge clk);
        while (idle_on && $urandom_range(99) < IDLE_PCT) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_item <= '{data_byte: b, stream_end: last_byte};
        do @(posedge clk); while (!in_ready);
        encode_byte(b, last_byte);
        bytes_sent++;
    endtask

    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (exp_chars.size() != 0)
            @(posedge clk);
    endtask

    task automatic send_group(logic [31:0] word, logic close);
        send_byte(word[31:24], 1'b0);
        send_byte(word[23:16], 1'b0);
        send_byte(word[15:8], 1'b0);
        send_byte(word[7:0], close);
    endtask

    task automatic test_zero_groups();
        send_group(32'h0000_0000, 1'b0);
        send_group(32'h0000_0000, 1'b1);
    endtask

    task automatic test_extreme_groups();
        send_group(32'hFFFF_FFFF, 1'b0);
        send_group(32'h0000_0001, 1'b1);
        send_group(32'hFFFF_FFFF, 1'b1);
    endtask

    // partial groups at the end of a stream never abbreviate to z
    task automatic test_short_tails();
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b1);
    endtask

    task automatic send_random_stream();
        int   len;
        int   kind;
        logic [7:0] b;

        len = $urandom_range(12, 1);
        for (int i = 0; i < len; i++) begin
            if (i % 4 == 0)
                kind = $urandom_range(3);
            case (kind)
                0:       b = ($urandom_range(7) == 0) ? 8'($urandom) : 8'h00;
                1:       b = ($urandom_range(3) == 0) ? 8'($urandom) : 8'hFF;
                default: b = 8'($urandom);
            endcase
            send_byte(b, i == len - 1);
        end
    endtask

    task automatic test_random_streams(int n_bytes);
        int target;

        target = bytes_sent + n_bytes;
        while (bytes_sent < target)
            send_random_stream();
    endtask

    // long stretch with no input gaps and the output always ready
    task automatic test_back_to_back(int n_bytes);
        idle_on = 1'b0;
        test_random_streams(n_bytes);
        idle_on = 1'b1;
    endtask

    initial begin
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;

        test_zero_groups();
        test_extreme_groups();
        test_short_tails();
        wait_drained();
        test_random_streams(60);
        wait_drained();
        test_back_to_back(40);
        test_random_streams(40);

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("tb: %0d bytes in %0d closed streams, %0d characters checked", bytes_sent,
                 streams_closed, chars_checked);
        $display("tb: %0d all-zero groups, %0d mismatches", z_groups, errors);
        if (errors == 0 && exp_chars.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
